@@ rtl/mfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mfr_pkg
// Types and constants shared by the meter frame receiver modules.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam logic [7:0] HEAD_BYTE  = 8'h68;
  localparam logic [7:0] TAIL_BYTE  = 8'h16;
  localparam int         ADDR_BYTES = 6;

  // Length bytes from this value upward give (L+1)/200 = 1, which earns the
  // timer ten extra ticks.
  localparam logic [7:0]  EXT_LEN_MIN = 8'd199;
  localparam logic [16:0] EXT_TICKS   = 17'd10;
  localparam logic [15:0] TIMER_MAX   = 16'hFFFF;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic CFG_MAX_LEN = 1'b0;
  localparam logic CFG_BASE_TO = 1'b1;

  localparam logic [7:0]  MAX_LEN_RST = 8'd255;
  localparam logic [15:0] BASE_TO_RST = 16'd100;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PAYLOAD   = 3'd1,
    EV_FRAME_OK  = 3'd2,
    EV_HEAD_ERR  = 3'd3,
    EV_TOO_LONG  = 3'd4,
    EV_TAIL_ERR  = 3'd5,
    EV_CSUM_ERR  = 3'd6,
    EV_TIMEOUT   = 3'd7
  } mfr_event_t;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_ADDR,
    ST_HEAD2,
    ST_CTRL_LEN,
    ST_DATA,
    ST_TAIL
  } mfr_state_t;

  // One classified item as it travels from the front end to the engine.
  typedef struct packed {
    logic       is_tick;
    logic       is_head;
    logic       is_tail;
    logic [7:0] rx_byte;
  } mfr_item_t;

  typedef struct packed {
    logic [7:0]  max_len;
    logic [15:0] base_to;
  } mfr_cfg_t;

endpackage

@@ rtl/mfr_front.sv @@
// ----------------------------------------------------------------------------
// mfr_front
// Input stage: takes items from the input channel and classifies them.
// ----------------------------------------------------------------------------
module mfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [7:0]        in_rx_byte,
  output logic              item_valid,
  input  logic              item_ready,
  output mfr_pkg::mfr_item_t item
);
  import mfr_pkg::*;

  logic      valid_r, valid_nxt;
  mfr_item_t item_r, item_nxt;
  logic      take;

  assign in_ready   = !valid_r || item_ready;
  assign take       = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = take || (valid_r && !item_ready);
    item_nxt  = item_r;
    if (take) begin
      item_nxt.is_tick = in_req_type;
      item_nxt.is_head = (in_rx_byte == HEAD_BYTE);
      item_nxt.is_tail = (in_rx_byte == TAIL_BYTE);
      item_nxt.rx_byte = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

@@ rtl/mfr_queue.sv @@
// ----------------------------------------------------------------------------
// mfr_queue
// Short queue between the front end and the frame engine.
// ----------------------------------------------------------------------------
module mfr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  mfr_pkg::mfr_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output mfr_pkg::mfr_item_t pop_item
);
  import mfr_pkg::*;

  mfr_item_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/mfr_engine.sv @@
// ----------------------------------------------------------------------------
// mfr_engine
// Frame state machine, frame timer and registered result stage.
// ----------------------------------------------------------------------------
module mfr_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  mfr_pkg::mfr_cfg_t  cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  mfr_pkg::mfr_item_t item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_event_res,
  output logic [7:0]         out_data_byte,
  output logic [7:0]         out_ctrl_code,
  output logic [47:0]        out_station_address,
  output logic [7:0]         out_payload_len
);
  import mfr_pkg::*;

  mfr_state_t  state_r, state_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        tmr_run_r, tmr_run_nxt;
  logic [15:0] tmr_cnt_r, tmr_cnt_nxt;
  logic [15:0] tmr_lim_r, tmr_lim_nxt;
  logic [47:0] addr_r, addr_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  len_r, len_nxt;

  logic        ovalid_r, ovalid_nxt;
  mfr_event_t  oevent_r, oevent_nxt;
  logic [7:0]  odata_r, odata_nxt;
  logic [7:0]  octrl_r, octrl_nxt;
  logic [47:0] oaddr_r, oaddr_nxt;
  logic [7:0]  olen_r, olen_nxt;

  logic        take;
  logic [7:0]  b;
  logic [15:0] tick_cnt;
  logic        expired;
  logic        too_long;
  logic [16:0] ext_lim;
  logic [15:0] ext_lim_sat;

  assign item_ready = !ovalid_r || out_ready;
  assign take       = item_valid && item_ready;
  assign b          = item.rx_byte;
  assign tick_cnt   = tmr_cnt_r + 16'd1;
  assign expired    = (tick_cnt >= tmr_lim_r);
  assign too_long   = (b > cfg.max_len);
  assign ext_lim    = {1'b0, cfg.base_to} + ((b >= EXT_LEN_MIN) ? EXT_TICKS : 17'd0);
  assign ext_lim_sat = ext_lim[16] ? TIMER_MAX : ext_lim[15:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    if (take) begin
      if (item.is_tick) begin
        if (!tmr_run_r || expired) begin
          state_nxt = ST_HUNT;
        end
      end else begin
        case (state_r)
          ST_HUNT: begin
            if (item.is_head) begin
              state_nxt = ST_ADDR;
            end
          end
          ST_ADDR: begin
            if (count_r == 8'(ADDR_BYTES - 1)) begin
              state_nxt = ST_HEAD2;
            end
          end
          ST_HEAD2: begin
            state_nxt = item.is_head ? ST_CTRL_LEN : ST_HUNT;
          end
          ST_CTRL_LEN: begin
            if (count_r != 8'd0) begin
              state_nxt = too_long ? ST_HUNT : ST_DATA;
            end
          end
          ST_DATA: begin
            if (count_r >= len_r) begin
              state_nxt = ST_TAIL;
            end
          end
          ST_TAIL:  state_nxt = ST_HUNT;
          default:  state_nxt = ST_HUNT;
        endcase
      end
    end
  end

  // Frame registers, timer and result.
  always_comb begin
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    tmr_run_nxt = tmr_run_r;
    tmr_cnt_nxt = tmr_cnt_r;
    tmr_lim_nxt = tmr_lim_r;
    addr_nxt    = addr_r;
    ctrl_nxt    = ctrl_r;
    len_nxt     = len_r;
    oevent_nxt  = oevent_r;
    odata_nxt   = odata_r;
    octrl_nxt   = octrl_r;
    oaddr_nxt   = oaddr_r;
    olen_nxt    = olen_r;
    ovalid_nxt  = take || (ovalid_r && !out_ready);
    if (take) begin
      oevent_nxt = EV_NONE;
      odata_nxt  = 8'd0;
      octrl_nxt  = 8'd0;
      oaddr_nxt  = 48'd0;
      olen_nxt   = 8'd0;
      if (item.is_tick) begin
        if (!tmr_run_r) begin
          count_nxt = 8'd0;
        end else begin
          tmr_cnt_nxt = tick_cnt;
          if (expired) begin
            count_nxt   = 8'd0;
            tmr_run_nxt = 1'b0;
            oevent_nxt  = EV_TIMEOUT;
          end
        end
      end else begin
        case (state_r)
          ST_HUNT: begin
            if (item.is_head) begin
              count_nxt   = 8'd0;
              addr_nxt    = 48'd0;
              ctrl_nxt    = 8'd0;
              len_nxt     = 8'd0;
              sum_nxt     = HEAD_BYTE;
              tmr_cnt_nxt = 16'd0;
              tmr_lim_nxt = cfg.base_to;
              tmr_run_nxt = 1'b1;
            end
          end
          ST_ADDR: begin
            addr_nxt[{count_r[2:0], 3'b000} +: 8] = b;
            sum_nxt   = sum_r + b;
            count_nxt = count_r + 8'd1;
          end
          ST_HEAD2: begin
            count_nxt = 8'd0;
            if (item.is_head) begin
              sum_nxt = sum_r + b;
            end else begin
              tmr_run_nxt = 1'b0;
              oevent_nxt  = EV_HEAD_ERR;
            end
          end
          ST_CTRL_LEN: begin
            sum_nxt = sum_r + b;
            if (count_r == 8'd0) begin
              ctrl_nxt  = b;
              count_nxt = 8'd1;
            end else begin
              len_nxt   = b;
              count_nxt = 8'd0;
              if (too_long) begin
                tmr_run_nxt = 1'b0;
                oevent_nxt  = EV_TOO_LONG;
              end else begin
                tmr_cnt_nxt = 16'd0;
                tmr_lim_nxt = ext_lim_sat;
                tmr_run_nxt = 1'b1;
              end
            end
          end
          ST_DATA: begin
            if (count_r < len_r) begin
              sum_nxt    = sum_r + b;
              count_nxt  = count_r + 8'd1;
              oevent_nxt = EV_PAYLOAD;
              odata_nxt  = b;
            end else begin
              sum_nxt = sum_r - b;
            end
          end
          ST_TAIL: begin
            count_nxt   = 8'd0;
            tmr_run_nxt = 1'b0;
            if (!item.is_tail) begin
              oevent_nxt = EV_TAIL_ERR;
            end else if (len_r > cfg.max_len) begin
              oevent_nxt = EV_TOO_LONG;
            end else if (sum_r != 8'd0) begin
              oevent_nxt = EV_CSUM_ERR;
            end else begin
              oevent_nxt = EV_FRAME_OK;
            end
            if (!item.is_tail || len_r <= cfg.max_len) begin
              octrl_nxt = ctrl_r;
              oaddr_nxt = addr_r;
              olen_nxt  = len_r;
            end
          end
          default: begin
            count_nxt   = 8'd0;
            tmr_run_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_HUNT;
      count_r   <= 8'd0;
      sum_r     <= 8'd0;
      tmr_run_r <= 1'b0;
      tmr_cnt_r <= 16'd0;
      tmr_lim_r <= 16'd0;
      addr_r    <= 48'd0;
      ctrl_r    <= 8'd0;
      len_r     <= 8'd0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      sum_r     <= sum_nxt;
      tmr_run_r <= tmr_run_nxt;
      tmr_cnt_r <= tmr_cnt_nxt;
      tmr_lim_r <= tmr_lim_nxt;
      addr_r    <= addr_nxt;
      ctrl_r    <= ctrl_nxt;
      len_r     <= len_nxt;
      ovalid_r  <= ovalid_nxt;
    end
    oevent_r <= oevent_nxt;
    odata_r  <= odata_nxt;
    octrl_r  <= octrl_nxt;
    oaddr_r  <= oaddr_nxt;
    olen_r   <= olen_nxt;
  end

  assign out_valid           = ovalid_r;
  assign out_event_res       = oevent_r;
  assign out_data_byte       = odata_r;
  assign out_ctrl_code       = octrl_r;
  assign out_station_address = oaddr_r;
  assign out_payload_len     = olen_r;

endmodule

@@ rtl/meter_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// meter_frame_receiver
// Receiver for meter frames: head, six address bytes, head, control, length,
// data, checksum and tail, with a frame timer driven by tick items.
// ----------------------------------------------------------------------------
// Each input item is either a received byte or a timer tick, and each one
// yields exactly one result item on the output channel: a payload byte as it
// arrives, a frame outcome at the tail or on an abort, or an empty event.
// The address, control byte and length accompany the frame-ok, tail-error
// and checksum-error outcomes only.
// An item is taken on every cycle in which in_valid and in_ready are high;
// sustained throughput is one item per cycle while out_ready stays high. From
// acceptance, an item passes in order through the input register, the
// two-entry queue and the result register before out_valid rises.
// When the output side stalls, the result register holds its item, the frame
// engine stops popping, the queue fills and in_ready falls once the input
// register is also occupied; nothing is dropped.
// Configuration writes on the cfg_ channel are always taken (cfg_ready is
// tied high) and should only happen while no items are in flight.
// Synchronous reset returns the receiver to head hunting with the timer
// stopped and restores max_payload_len to 255 and base_timeout to 100.
// ----------------------------------------------------------------------------
module meter_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_ctrl_code,
  output logic [47:0] out_station_address,
  output logic [7:0]  out_payload_len,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import mfr_pkg::*;

  mfr_cfg_t  cfg_r, cfg_nxt;
  logic      front_valid, front_ready;
  mfr_item_t front_item;
  logic      q_valid, q_ready;
  mfr_item_t q_item;

  // Configuration registers; a write lands on the next edge.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_LEN: cfg_nxt.max_len = cfg_wdata[7:0];
        CFG_BASE_TO: cfg_nxt.base_to = cfg_wdata;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_len <= MAX_LEN_RST;
      cfg_r.base_to <= BASE_TO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: registers and classifies each incoming item.
  mfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .in_rx_byte (in_rx_byte),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  // The queue lets the front end keep taking items while the engine waits.
  mfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .push_item (front_item),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item)
  );

  // Back end: frame state machine, timer and result register.
  mfr_engine u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .item_valid         (q_valid),
    .item_ready         (q_ready),
    .item               (q_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_data_byte      (out_data_byte),
    .out_ctrl_code      (out_ctrl_code),
    .out_station_address(out_station_address),
    .out_payload_len    (out_payload_len)
  );

endmodule
